>>> src/swd_pkg.sv
package swd_pkg;

  // Field widths
  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 17;
  localparam int COEFF_W    = 17;
  localparam int THR_W      = 24;
  localparam int MODE_W     = 3;
  localparam int STATE_W    = 27;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int STEP_W     = 3;
  localparam int NUM_STEPS  = 8;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_PRE_GAIN     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SHAPE_MODE   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_FILTER_COEFF = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_POST_GAIN    = 3'd4;

  // Reset values
  localparam logic [GAIN_W-1:0]  PRE_GAIN_RST  = 17'd16384;
  localparam logic [MODE_W-1:0]  MODE_RST      = 3'd0;
  localparam logic [THR_W-1:0]   THRESHOLD_RST = 24'd8388608;
  localparam logic [COEFF_W-1:0] COEFF_RST     = 17'd65536;
  localparam logic [GAIN_W-1:0]  POST_GAIN_RST = 17'd16384;
  localparam logic signed [STATE_W-1:0] LOWPASS_RST = 27'sd8388608;

  // Shaping modes; the two spare codes behave as bypass
  typedef enum logic [MODE_W-1:0] {
    MODE_BYPASS    = 3'd0,
    MODE_CLIP      = 3'd1,
    MODE_FOLD      = 3'd2,
    MODE_WRAP_PLUS = 3'd3,
    MODE_FLAT_WRAP = 3'd4,
    MODE_WRAP_MIN  = 3'd5
  } shape_mode_t;

  // Channel select
  localparam logic CH_L = 1'b0;
  localparam logic CH_R = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
  } out_item_t;

  // Microcode fields
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_PRE,
    MUL_DIFF,
    MUL_POST
  } mul_op_t;

  typedef enum logic [1:0] {
    ALU_NONE,
    ALU_SHAPE,
    ALU_UPD,
    ALU_OUT
  } alu_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_WAIT_OUT
  } jump_t;

  typedef struct packed {
    mul_op_t mul_op;
    logic    mul_ch;
    alu_op_t alu_op;
    logic    alu_ch;
    jump_t   jump;
  } ucode_t;

  // Datapath control handed from the sequencer
  typedef struct packed {
    mul_op_t mul_op;
    logic    mul_ch;
    alu_op_t alu_op;
    logic    alu_ch;
    logic    capture;
    logic    out_load;
  } ctrl_t;

  // Program: multiplier works one channel ahead of the post-multiply unit
  localparam ucode_t UCODE [NUM_STEPS] = '{
    '{MUL_NONE, CH_L, ALU_NONE,  CH_L, JMP_WAIT_IN},
    '{MUL_PRE,  CH_L, ALU_NONE,  CH_L, JMP_NEXT},
    '{MUL_PRE,  CH_R, ALU_SHAPE, CH_L, JMP_NEXT},
    '{MUL_DIFF, CH_L, ALU_SHAPE, CH_R, JMP_NEXT},
    '{MUL_DIFF, CH_R, ALU_UPD,   CH_L, JMP_NEXT},
    '{MUL_POST, CH_L, ALU_UPD,   CH_R, JMP_NEXT},
    '{MUL_POST, CH_R, ALU_OUT,   CH_L, JMP_NEXT},
    '{MUL_NONE, CH_L, ALU_OUT,   CH_R, JMP_WAIT_OUT}
  };

endpackage

>>> src/swd_seq.sv
module swd_seq
  import swd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output ctrl_t ctrl
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  ucode_t            cw;
  logic              out_free;
  logic              in_acc;

  // Control word for the current step
  assign cw       = UCODE[step_r];
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (cw.jump == JMP_WAIT_IN);
  assign in_acc   = in_valid && in_ready;

  // Next step: conditional jumps on the input and output handshakes
  always_comb begin
    step_nxt = step_r;
    unique case (cw.jump)
      JMP_WAIT_IN: begin
        if (in_valid) step_nxt = step_r + STEP_W'(1);
      end
      JMP_WAIT_OUT: begin
        if (out_free) step_nxt = '0;
      end
      default: begin
        step_nxt = step_r + STEP_W'(1);
      end
    endcase
  end

  // Datapath controls
  always_comb begin
    ctrl.mul_op   = cw.mul_op;
    ctrl.mul_ch   = cw.mul_ch;
    ctrl.alu_op   = cw.alu_op;
    ctrl.alu_ch   = cw.alu_ch;
    ctrl.capture  = in_acc;
    ctrl.out_load = (cw.jump == JMP_WAIT_OUT) && out_free;
  end

  // Result valid: held until taken, reloaded on completion
  assign out_valid_nxt = (out_valid_r && !out_ready) || ctrl.out_load;
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> src/swd_dp.sv
module swd_dp
  import swd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_t               ctrl,
  input  in_item_t            in_data,
  input  logic [GAIN_W-1:0]   pre_gain,
  input  logic [MODE_W-1:0]   shape_mode,
  input  logic [THR_W-1:0]    threshold,
  input  logic [COEFF_W-1:0]  filter_coeff,
  input  logic [GAIN_W-1:0]   post_gain,
  output out_item_t           out_data
);

  localparam int MA_W = STATE_W + 1;          // multiplier signed operand
  localparam int MB_W = GAIN_W + 1;           // unsigned operand made signed
  localparam int P_W  = MA_W + MB_W;          // product
  localparam int X_W  = STATE_W + 2;          // shaping word

  function automatic logic signed [STATE_W-1:0] sat27(input logic signed [30:0] v);
    logic signed [STATE_W-1:0] res;
    begin
      if (v > 31'sd67108863)       res = 27'sd67108863;
      else if (v < -31'sd67108864) res = -27'sd67108864;
      else                         res = v[STATE_W-1:0];
      return res;
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [30:0] v);
    logic signed [SAMPLE_W-1:0] res;
    begin
      if (v > 31'sd8388607)       res = 24'sd8388607;
      else if (v < -31'sd8388608) res = -24'sd8388608;
      else                        res = v[SAMPLE_W-1:0];
      return res;
    end
  endfunction

  in_item_t                   in_r;
  out_item_t                  out_r;
  logic signed [P_W-1:0]      prod_r;
  logic signed [STATE_W-1:0]  y_left_r, y_right_r;
  logic signed [STATE_W-1:0]  st_left_r, st_right_r, st_nxt;
  logic signed [SAMPLE_W-1:0] res_left_r;

  logic signed [MA_W-1:0]     mul_a;
  logic signed [MB_W-1:0]     mul_b;
  logic signed [P_W-1:0]      prod_nxt;
  logic signed [SAMPLE_W-1:0] in_m;
  logic signed [STATE_W-1:0]  st_m, y_m, st_a;
  logic signed [P_W:0]        prod_ext, sum14, sum16;
  logic signed [X_W-1:0]      x, t, two_t, y_raw;
  logic signed [STATE_W-1:0]  y_nxt;
  logic                       above, below;
  logic signed [30:0]         inc, upd_sum, o_full;
  logic signed [SAMPLE_W-1:0] o_sat;

  // Multiplier operand selection
  always_comb begin
    in_m  = ctrl.mul_ch ? in_r.in_right : in_r.in_left;
    st_m  = ctrl.mul_ch ? st_right_r : st_left_r;
    y_m   = ctrl.mul_ch ? y_right_r : y_left_r;
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.mul_op)
      MUL_PRE: begin
        mul_a = MA_W'(in_m);
        mul_b = $signed({1'b0, pre_gain});
      end
      MUL_DIFF: begin
        mul_a = MA_W'(y_m) - MA_W'(st_m);
        mul_b = $signed({1'b0, filter_coeff});
      end
      MUL_POST: begin
        mul_a = MA_W'(st_m);
        mul_b = $signed({1'b0, post_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // Round half up of the held product
  assign prod_ext = (P_W+1)'(prod_r);
  assign sum14    = prod_ext + (P_W+1)'(8192);
  assign sum16    = prod_ext + (P_W+1)'(32768);
  assign x        = sum14[X_W+13:14];
  assign inc      = sum16[46:16];
  assign o_full   = sum14[44:14];

  // Shaping against +/- threshold
  always_comb begin
    t     = $signed({5'b0, threshold});
    two_t = $signed({4'b0, threshold, 1'b0});
    above = x > t;
    below = x < -t;
    y_raw = x;
    case (shape_mode)
      MODE_CLIP: begin
        if (above) y_raw = t;
        if (below) y_raw = -t;
      end
      MODE_FOLD: begin
        if (above) y_raw = two_t - x;
        if (below) y_raw = -two_t - x;
      end
      MODE_WRAP_PLUS: begin
        if (above) y_raw = x - two_t;
        if (below) y_raw = x + two_t;
      end
      MODE_FLAT_WRAP: begin
        if (above) y_raw = -t;
        if (below) y_raw = t;
      end
      MODE_WRAP_MIN: begin
        if (above || below) y_raw = -x;
      end
      default: begin
        y_raw = x;
      end
    endcase
    y_nxt = sat27(31'(y_raw));
  end

  // Lowpass update and output scaling
  always_comb begin
    st_a    = ctrl.alu_ch ? st_right_r : st_left_r;
    upd_sum = 31'(st_a) + inc;
    st_nxt  = sat27(upd_sum);
    o_sat   = sat24(o_full);
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctrl.capture) in_r <= in_data;
    if (ctrl.mul_op != MUL_NONE) prod_r <= prod_nxt;
    if (ctrl.alu_op == ALU_SHAPE) begin
      if (ctrl.alu_ch == CH_R) y_right_r <= y_nxt;
      else                     y_left_r  <= y_nxt;
    end
    if (ctrl.alu_op == ALU_OUT && ctrl.alu_ch == CH_L) res_left_r <= o_sat;
    if (ctrl.out_load) begin
      out_r.out_left  <= res_left_r;
      out_r.out_right <= o_sat;
    end
  end

  // Filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_left_r  <= LOWPASS_RST;
      st_right_r <= LOWPASS_RST;
    end else if (ctrl.alu_op == ALU_UPD) begin
      if (ctrl.alu_ch == CH_R) st_right_r <= st_nxt;
      else                     st_left_r  <= st_nxt;
    end
  end

  assign out_data = out_r;

endmodule

>>> src/stereo_waveshaper_distortion.sv
// Channel   Handshake             Payload
// in_       in_valid / in_ready   in_data  (in_left, in_right, s24)
// out_      out_valid / out_ready out_data (out_left, out_right, s24)
// cfg_      cfg_we                cfg_addr (3b), cfg_wdata (24b)
//
// Each item goes through the accept step and then a 7-step microprogram
// that shares a single 28x18 multiplier between both channels.
// The next item is taken while a result waits in the output register;
// the last step holds until that register is free.
// Reset (rst_n, synchronous) restores the configuration and sequencer
// registers and sets both lowpass states to +1.0. No clearing pass.
module stereo_waveshaper_distortion
  import swd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [GAIN_W-1:0]  pre_gain_r;
  logic [MODE_W-1:0]  shape_mode_r;
  logic [THR_W-1:0]   threshold_r;
  logic [COEFF_W-1:0] filter_coeff_r;
  logic [GAIN_W-1:0]  post_gain_r;
  ctrl_t              ctrl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_gain_r     <= PRE_GAIN_RST;
      shape_mode_r   <= MODE_RST;
      threshold_r    <= THRESHOLD_RST;
      filter_coeff_r <= COEFF_RST;
      post_gain_r    <= POST_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PRE_GAIN:     pre_gain_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_SHAPE_MODE:   shape_mode_r   <= cfg_wdata[MODE_W-1:0];
        CFG_THRESHOLD:    threshold_r    <= cfg_wdata[THR_W-1:0];
        CFG_FILTER_COEFF: filter_coeff_r <= cfg_wdata[COEFF_W-1:0];
        CFG_POST_GAIN:    post_gain_r    <= cfg_wdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Microprogram sequencer
  swd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  // Arithmetic datapath
  swd_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .in_data      (in_data),
    .pre_gain     (pre_gain_r),
    .shape_mode   (shape_mode_r),
    .threshold    (threshold_r),
    .filter_coeff (filter_coeff_r),
    .post_gain    (post_gain_r),
    .out_data     (out_data)
  );

endmodule

>>> src/swd_checker.sv
module swd_checker
  import swd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Busy after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

  // A fresh result traces back to an accepted item
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 8))
    else $error("result without matching item");

endmodule

bind stereo_waveshaper_distortion swd_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import swd_pkg::*;

  // Run shape
  localparam int SETTLE_CYCLES   = 8;
  localparam int QUIET_LIMIT     = 5000;
  localparam int RAND_PHASES     = 12;
  localparam int ITEMS_PER_PHASE = 150;

  // Register values of interest
  localparam logic [GAIN_W-1:0]  GAIN_UNITY  = 17'd16384;
  localparam logic [GAIN_W-1:0]  GAIN_FOUR   = 17'd65536;
  localparam logic [GAIN_W-1:0]  GAIN_MAX    = '1;
  localparam logic [THR_W-1:0]   THR_UNITY   = 24'd8388608;
  localparam logic [THR_W-1:0]   THR_HALF    = 24'd4194304;
  localparam logic [THR_W-1:0]   THR_MAX     = '1;
  localparam logic [COEFF_W-1:0] COEFF_UNITY = 17'd65536;
  localparam logic [COEFF_W-1:0] COEFF_MAX   = '1;
  localparam logic [MODE_W-1:0]  SPARE_MODE_A = 3'd6;
  localparam logic [MODE_W-1:0]  SPARE_MODE_B = 3'd7;

  // Saturation bounds
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) <<< (SAMPLE_W - 1));
  localparam longint STATE_MAX  = (longint'(1) <<< (STATE_W - 1)) - 1;
  localparam longint STATE_MIN  = -(longint'(1) <<< (STATE_W - 1));

  typedef struct packed {
    logic [GAIN_W-1:0]  pre;
    logic [MODE_W-1:0]  mode;
    logic [THR_W-1:0]   thr;
    logic [COEFF_W-1:0] coeff;
    logic [GAIN_W-1:0]  post;
    in_item_t           smp;
    logic               typed;
    out_item_t          want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow of the register file and the two lowpass states
  logic [GAIN_W-1:0]  cur_pre;
  logic [MODE_W-1:0]  cur_mode;
  logic [THR_W-1:0]   cur_thr;
  logic [COEFF_W-1:0] cur_coeff;
  logic [GAIN_W-1:0]  cur_post;
  longint             lowpass_st [2];

  out_item_t pending_pairs [$];
  stim_row_t directed_rows [$];
  bit        steady;
  int        errors;
  int        n_items;
  int        n_results;
  int        quiet_cycles;

  stereo_waveshaper_distortion dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------

  // round half up of p / 2^s
  function automatic longint round_div(longint p, int s);
    return (p + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint waveshape(longint x);
    longint t;
    longint y;
    bit     above;
    bit     below;
    t     = longint'(cur_thr);
    above = x > t;
    below = x < -t;
    y     = x;
    case (cur_mode)
      MODE_CLIP: begin
        if (above) y = t;
        if (below) y = -t;
      end
      MODE_FOLD: begin
        if (above) y = 2 * t - x;
        if (below) y = -2 * t - x;
      end
      MODE_WRAP_PLUS: begin
        if (above) y = x - 2 * t;
        if (below) y = x + 2 * t;
      end
      MODE_FLAT_WRAP: begin
        if (above) y = -t;
        if (below) y = t;
      end
      MODE_WRAP_MIN: begin
        if (above || below) y = -x;
      end
      default: ; // bypass, spare codes included
    endcase
    return clamp(y, STATE_MIN, STATE_MAX);
  endfunction

  // gain, shape, lowpass, post gain for one channel; advances its state
  function automatic logic signed [SAMPLE_W-1:0] distort_channel(
      logic signed [SAMPLE_W-1:0] s, logic ch);
    longint x;
    longint y;
    longint o;
    x = round_div(longint'(s) * longint'(cur_pre), 14);
    y = waveshape(x);
    lowpass_st[ch] = clamp(lowpass_st[ch] +
                           round_div((y - lowpass_st[ch]) * longint'(cur_coeff), 16),
                           STATE_MIN, STATE_MAX);
    o = clamp(round_div(lowpass_st[ch] * longint'(cur_post), 14), SAMPLE_MIN, SAMPLE_MAX);
    return o[SAMPLE_W-1:0];
  endfunction

  // ---------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------

  function automatic void add_row(logic [GAIN_W-1:0] pre, logic [MODE_W-1:0] mode,
                                  logic [THR_W-1:0] thr, logic [COEFF_W-1:0] coeff,
                                  logic [GAIN_W-1:0] post, int l, int r,
                                  bit typed, int el, int er);
    stim_row_t row;
    row.pre            = pre;
    row.mode           = mode;
    row.thr            = thr;
    row.coeff          = coeff;
    row.post           = post;
    row.smp.in_left    = l[SAMPLE_W-1:0];
    row.smp.in_right   = r[SAMPLE_W-1:0];
    row.typed          = typed;
    row.want.out_left  = el[SAMPLE_W-1:0];
    row.want.out_right = er[SAMPLE_W-1:0];
    directed_rows.push_back(row);
  endfunction

  // random junk above the register's width; the block must drop it
  function automatic logic [CFG_DATA_W-1:0] pad_upper(logic [CFG_DATA_W-1:0] v, int w);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    if ($urandom_range(0, 2) != 0) junk = '0;
    return v | ((junk >> w) << w);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_setting(logic [CFG_ADDR_W-1:0] addr);
    logic [CFG_DATA_W-1:0] v;
    case (addr)
      CFG_THRESHOLD: begin
        case ($urandom_range(0, 5))
          0: v = '0;
          1: v = CFG_DATA_W'(THR_UNITY);
          2: v = CFG_DATA_W'(THR_MAX);
          3: v = CFG_DATA_W'($urandom_range(0, 1000));
          4: v = CFG_DATA_W'($urandom_range(0, THR_UNITY));
          default: v = CFG_DATA_W'($urandom_range(0, THR_MAX));
        endcase
        return v;
      end
      CFG_FILTER_COEFF: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = CFG_DATA_W'(COEFF_UNITY);
          2: v = CFG_DATA_W'(COEFF_MAX);
          3: v = CFG_DATA_W'($urandom_range(1, 4096));
          default: v = CFG_DATA_W'($urandom_range(0, COEFF_MAX));
        endcase
        return pad_upper(v, COEFF_W);
      end
      default: begin
        case ($urandom_range(0, 5))
          0: v = '0;
          1: v = CFG_DATA_W'(GAIN_UNITY);
          2: v = CFG_DATA_W'(GAIN_FOUR);
          3: v = CFG_DATA_W'(GAIN_MAX);
          4: v = CFG_DATA_W'($urandom_range(0, GAIN_FOUR));
          default: v = CFG_DATA_W'($urandom_range(0, GAIN_MAX));
        endcase
        return pad_upper(v, GAIN_W);
      end
    endcase
  endfunction

  // full range mostly, with extremes, tiny values and values near the threshold
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] raw;
    longint v;
    raw = SAMPLE_W'($urandom);
    v   = longint'($signed(raw));
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      1: v = longint'($urandom_range(0, 64)) - 32;
      2: begin
        if (cur_pre != 0) begin
          v = (longint'(cur_thr) * 16384) / longint'(cur_pre) +
              longint'($urandom_range(0, 4)) - 2;
          if ($urandom_range(0, 1)) v = -v;
          v = clamp(v, SAMPLE_MIN, SAMPLE_MAX);
        end
      end
      default: ;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------

  task automatic send_pair(in_item_t s, bit typed, out_item_t want);
    int        gap;
    out_item_t pred;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    pred.out_left  = distort_channel(s.in_left, CH_L);
    pred.out_right = distort_channel(s.in_right, CH_R);
    pending_pairs.push_back(typed ? want : pred);
    n_items++;
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      CFG_PRE_GAIN:     cur_pre   = data[GAIN_W-1:0];
      CFG_SHAPE_MODE:   cur_mode  = data[MODE_W-1:0];
      CFG_THRESHOLD:    cur_thr   = data[THR_W-1:0];
      CFG_FILTER_COEFF: cur_coeff = data[COEFF_W-1:0];
      CFG_POST_GAIN:    cur_post  = data[GAIN_W-1:0];
      default: ; // unmapped index, ignored
    endcase
  endtask

  task automatic cfg_done();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: ready with random stalls, mostly short
  initial begin : result_ready
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 15) begin
          stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 50);
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------

  function automatic void check_field(string name, logic signed [SAMPLE_W-1:0] want,
                                      logic signed [SAMPLE_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, actual %0d / %0d",
                 $time, out_data.out_left, out_data.out_right);
      end else begin
        want = pending_pairs.pop_front();
        check_field("out_left", want.out_left, out_data.out_left);
        check_field("out_right", want.out_right, out_data.out_right);
        n_results++;
      end
    end
  end

  // Watchdog: cycles with work outstanding but no item moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (pending_pairs.size() == 0 && !in_valid)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------

  initial begin : stimulus
    stim_row_t row;
    in_item_t  smp;
    int        ph;
    int        k;
    int        a;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    steady       = 1'b0;
    errors       = 0;
    n_items      = 0;
    n_results    = 0;
    quiet_cycles = 0;
    cur_pre      = PRE_GAIN_RST;
    cur_mode     = MODE_RST;
    cur_thr      = THRESHOLD_RST;
    cur_coeff    = COEFF_RST;
    cur_post     = POST_GAIN_RST;
    lowpass_st[CH_L] = longint'(LOWPASS_RST);
    lowpass_st[CH_R] = longint'(LOWPASS_RST);

    // Directed table: pre, mode, thr, coeff, post, in L/R, typed?, expected L/R
    // coefficient zero holds the +1.0 reset state, which saturates on output
    add_row(GAIN_UNITY, MODE_BYPASS, THR_UNITY, '0, GAIN_UNITY, 0, 0, 1, 8388607, 8388607);
    add_row(GAIN_UNITY, MODE_BYPASS, THR_UNITY, '0, GAIN_UNITY,
            8388607, -8388608, 1, 8388607, 8388607);
    // unity everything passes samples straight through
    add_row(GAIN_UNITY, MODE_BYPASS, THR_UNITY, COEFF_UNITY, GAIN_UNITY,
            8388607, -8388608, 1, 8388607, -8388608);
    add_row(GAIN_UNITY, MODE_BYPASS, THR_UNITY, COEFF_UNITY, GAIN_UNITY, -1, 1, 1, -1, 1);
    add_row(GAIN_UNITY, MODE_BYPASS, THR_UNITY, COEFF_UNITY, GAIN_UNITY, 0, 0, 1, 0, 0);
    // gain extremes, output saturation
    add_row(GAIN_FOUR, MODE_BYPASS, THR_UNITY, COEFF_UNITY, GAIN_UNITY,
            8388607, -8388608, 1, 8388607, -8388608);
    add_row(GAIN_MAX, MODE_BYPASS, THR_UNITY, COEFF_UNITY, GAIN_UNITY,
            3000000, -3000000, 0, 0, 0);
    add_row('0, MODE_BYPASS, THR_UNITY, COEFF_UNITY, GAIN_UNITY, 8388607, -8388608, 1, 0, 0);
    // each shaping mode against half scale
    add_row(GAIN_UNITY, MODE_CLIP, THR_HALF, COEFF_UNITY, GAIN_UNITY,
            8388607, -8388608, 1, 4194304, -4194304);
    add_row(GAIN_UNITY, MODE_CLIP, THR_HALF, COEFF_UNITY, GAIN_UNITY,
            4194304, -4194304, 1, 4194304, -4194304);
    add_row(GAIN_UNITY, MODE_FOLD, THR_HALF, COEFF_UNITY, GAIN_UNITY,
            6291456, -6291456, 1, 2097152, -2097152);
    add_row(GAIN_UNITY, MODE_WRAP_PLUS, THR_HALF, COEFF_UNITY, GAIN_UNITY,
            6291456, -6291456, 1, -2097152, 2097152);
    add_row(GAIN_UNITY, MODE_FLAT_WRAP, THR_HALF, COEFF_UNITY, GAIN_UNITY,
            5000000, -5000000, 1, -4194304, 4194304);
    add_row(GAIN_UNITY, MODE_WRAP_MIN, THR_HALF, COEFF_UNITY, GAIN_UNITY,
            5000000, -4194305, 1, -5000000, 4194305);
    add_row(GAIN_UNITY, MODE_WRAP_MIN, THR_HALF, COEFF_UNITY, GAIN_UNITY,
            4194303, -4194304, 1, 4194303, -4194304);
    // spare mode codes behave as bypass
    add_row(GAIN_FOUR, SPARE_MODE_A, THR_HALF, COEFF_UNITY, GAIN_UNITY,
            8388607, 123456, 0, 0, 0);
    add_row(GAIN_UNITY, SPARE_MODE_B, THR_HALF, COEFF_UNITY, GAIN_UNITY,
            7000000, -7000000, 1, 7000000, -7000000);
    // zero threshold: anything nonzero is beyond it
    add_row(GAIN_UNITY, MODE_CLIP, '0, COEFF_UNITY, GAIN_UNITY, 0, 5, 1, 0, 0);
    add_row(GAIN_UNITY, MODE_FOLD, '0, COEFF_UNITY, GAIN_UNITY, 1, -1, 1, -1, 1);
    // largest threshold with largest gain
    add_row(GAIN_MAX, MODE_WRAP_PLUS, THR_MAX, COEFF_UNITY, GAIN_UNITY,
            8388607, -8388608, 0, 0, 0);
    // coefficient above unity overshoots into state saturation; then a half coefficient
    add_row(GAIN_FOUR, MODE_BYPASS, THR_UNITY, COEFF_MAX, GAIN_UNITY,
            8388607, -8388608, 0, 0, 0);
    add_row(GAIN_FOUR, MODE_BYPASS, THR_UNITY, COEFF_MAX, GAIN_UNITY,
            -8388608, 8388607, 0, 0, 0);
    add_row(GAIN_UNITY, MODE_BYPASS, THR_UNITY, 17'd32768, GAIN_UNITY,
            8388607, -8388608, 0, 0, 0);
    // post gain extremes
    add_row(GAIN_UNITY, MODE_BYPASS, THR_UNITY, COEFF_UNITY, GAIN_MAX,
            5000000, -5000000, 0, 0, 0);
    add_row(GAIN_UNITY, MODE_BYPASS, THR_UNITY, COEFF_UNITY, '0, 8388607, -8388608, 1, 0, 0);

    // Reset
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part; registers change only with the block idle
    for (k = 0; k < directed_rows.size(); k++) begin
      row = directed_rows[k];
      if ({row.pre, row.mode, row.thr, row.coeff, row.post} !=
          {cur_pre, cur_mode, cur_thr, cur_coeff, cur_post}) begin
        settle();
        if (row.pre != cur_pre)
          cfg_write(CFG_PRE_GAIN, pad_upper(CFG_DATA_W'(row.pre), GAIN_W));
        if (row.mode != cur_mode)
          cfg_write(CFG_SHAPE_MODE, pad_upper(CFG_DATA_W'(row.mode), MODE_W));
        if (row.thr != cur_thr)
          cfg_write(CFG_THRESHOLD, row.thr);
        if (row.coeff != cur_coeff)
          cfg_write(CFG_FILTER_COEFF, pad_upper(CFG_DATA_W'(row.coeff), COEFF_W));
        if (row.post != cur_post)
          cfg_write(CFG_POST_GAIN, pad_upper(CFG_DATA_W'(row.post), GAIN_W));
        cfg_done();
      end
      send_pair(row.smp, row.typed, row.want);
    end

    // Random phases, each with a fresh register setting
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      cfg_write(CFG_PRE_GAIN, random_setting(CFG_PRE_GAIN));
      cfg_write(CFG_SHAPE_MODE, pad_upper(CFG_DATA_W'(ph % 8), MODE_W));
      cfg_write(CFG_THRESHOLD, random_setting(CFG_THRESHOLD));
      cfg_write(CFG_FILTER_COEFF, random_setting(CFG_FILTER_COEFF));
      cfg_write(CFG_POST_GAIN, random_setting(CFG_POST_GAIN));
      // writes to unmapped indexes must change nothing
      if ($urandom_range(0, 1)) begin
        for (a = CFG_POST_GAIN + 1; a < (1 << CFG_ADDR_W); a++)
          cfg_write(CFG_ADDR_W'(a), CFG_DATA_W'($urandom));
      end
      cfg_done();
      steady = ($urandom_range(0, 3) == 0);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        smp.in_left  = pick_sample();
        smp.in_right = pick_sample();
        send_pair(smp, 1'b0, '0);
      end
    end

    // Drain and finish
    steady = 1'b0;
    settle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    $display("%0d sample pairs sent, %0d results checked, %0d mismatches",
             n_items, n_results, errors);
    $display("covered %0d directed rows and %0d random register settings, all shaping modes",
             directed_rows.size(), RAND_PHASES);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
